/* src/a7da_pkg.sv */
// Package for the Adam7 deinterlace address core.
// Holds the pass geometry tables, register index codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package a7da_pkg;

  localparam int NUM_PASSES = 7;
  localparam int DIM_WIDTH  = 16;

  typedef logic [2:0] pass_t;

  // Origin of each pass in the full image and log2 of its stride.
  localparam logic [DIM_WIDTH-1:0] START_X [NUM_PASSES] = '{0, 4, 0, 2, 0, 1, 0};
  localparam logic [DIM_WIDTH-1:0] START_Y [NUM_PASSES] = '{0, 0, 4, 0, 2, 0, 1};
  localparam logic [1:0]           SHIFT_X [NUM_PASSES] = '{3, 3, 2, 2, 1, 1, 0};
  localparam logic [1:0]           SHIFT_Y [NUM_PASSES] = '{3, 3, 3, 2, 2, 1, 1};

  // Configuration register indexes.
  localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_BITS_PER_PIXEL = 2'd2;

  // Per-pass bounds derived from the image size.
  typedef struct packed {
    logic [NUM_PASSES-1:0]                nonempty;
    logic                                 any;
    pass_t                                first;
    logic [NUM_PASSES-1:0][DIM_WIDTH-1:0] last_col;
    logic [NUM_PASSES-1:0][DIM_WIDTH-1:0] last_row;
  } geom_t;

endpackage

`default_nettype wire

/* src/a7da_geom.sv */
// Pass geometry for the Adam7 deinterlace address core.
// Derives which passes are nonempty and the last column and row index of each.
// Depends on a7da_pkg.
`timescale 1ns / 1ps
`default_nettype none

module a7da_geom
  import a7da_pkg::*;
(
  input  wire logic [DIM_WIDTH-1:0] image_width,
  input  wire logic [DIM_WIDTH-1:0] image_height,
  output geom_t                     geom
);

  always_comb begin
    geom = '0;
    for (int p = 0; p < NUM_PASSES; p++) begin
      geom.nonempty[p] = (image_width > START_X[p]) && (image_height > START_Y[p]);
      // Only meaningful when the pass is nonempty, so the subtraction cannot wrap.
      geom.last_col[p] = (image_width - START_X[p] - 16'd1) >> SHIFT_X[p];
      geom.last_row[p] = (image_height - START_Y[p] - 16'd1) >> SHIFT_Y[p];
    end
    geom.any = |geom.nonempty;
    for (int p = NUM_PASSES - 1; p >= 0; p--) begin
      if (geom.nonempty[p]) begin
        geom.first = 3'(p);
      end
    end
  end

endmodule

`default_nettype wire

/* src/adam7_deinterlace_addr_core.sv */
// Top level of the Adam7 deinterlace address core.
// Walks the seven interlace passes and tags each pixel with its place in the image.
// Depends on a7da_pkg and a7da_geom.
`timescale 1ns / 1ps
`default_nettype none

// Pixels of an Adam7-interlaced image enter one beat at a time in transmission
// order (pass 1 to 7, rows top to bottom, columns left to right) and leave with
// their column, row and linear index (row * width + column) in the full image;
// tlast marks the final pixel of the image, after which the walk starts over at
// the first nonempty pass. Passes that are empty for the configured size are
// skipped. The core takes one beat per clock while the output is not stalled; an
// accepted beat is registered in stage one and then in the output register, where
// the index multiply lands. The pass position counters advance once per accepted
// pixel. Writing any size register (or the pixel size register, which is not
// stored and changes no output) restarts the walk. With a zero width or height
// every pass is empty and pixels are accepted and dropped without a result.
module adam7_deinterlace_addr_core
  import a7da_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // Configuration write channel.
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  // Input stream.
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [63:0]  s_axis_tdata,   // pixel_value[63:0]
  // Output stream.
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata,   // out_value[63:0], dest_column[79:64],
                                            // dest_row[95:80], dest_index[127:96]
  output logic              m_axis_tlast    // last_pixel
);

  // Size registers keep at most COORD_BITS bits.
  localparam int DIM_BITS = (COORD_BITS < DIM_WIDTH) ? COORD_BITS : DIM_WIDTH;
  localparam int CMP_BITS = (COORD_BITS > DIM_WIDTH) ? COORD_BITS : DIM_WIDTH;

  logic [DIM_WIDTH-1:0]  image_width;
  logic [DIM_WIDTH-1:0]  image_height;
  pass_t                 current_pass;
  logic [COORD_BITS-1:0] pass_column;
  logic [COORD_BITS-1:0] pass_row;
  logic                  restart;     // walk must begin at the first nonempty pass

  geom_t geom;

  a7da_geom u_geom (
    .image_width  (image_width),
    .image_height (image_height),
    .geom         (geom)
  );

  // First pipeline stage: coordinates in the full image.
  logic                 s1_valid;
  logic [63:0]          s1_value;
  logic [DIM_WIDTH-1:0] s1_col;
  logic [DIM_WIDTH-1:0] s1_row;
  logic                 s1_last;

  logic in_fire, cfg_fire, s1_advance;

  assign cfg_ready     = 1'b1;
  assign cfg_fire      = cfg_valid && cfg_ready;
  assign s1_advance    = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Position of the pixel being accepted.
  pass_t                 eff_pass;
  pass_t                 next_pass;
  logic                  next_found;
  logic                  at_last_col, at_last_row;
  logic [DIM_WIDTH-1:0]  col_now, row_now;

  always_comb begin
    eff_pass = restart ? geom.first : current_pass;

    at_last_col = CMP_BITS'(pass_column) == CMP_BITS'(geom.last_col[eff_pass]);
    at_last_row = CMP_BITS'(pass_row) == CMP_BITS'(geom.last_row[eff_pass]);

    col_now = START_X[eff_pass] +
              (DIM_WIDTH'(pass_column[DIM_BITS-1:0]) << SHIFT_X[eff_pass]);
    row_now = START_Y[eff_pass] +
              (DIM_WIDTH'(pass_row[DIM_BITS-1:0]) << SHIFT_Y[eff_pass]);

    // Nearest nonempty pass after the current one.
    next_pass  = '0;
    next_found = 1'b0;
    for (int p = NUM_PASSES - 1; p >= 0; p--) begin
      if (geom.nonempty[p] && (3'(p) > eff_pass)) begin
        next_pass  = 3'(p);
        next_found = 1'b1;
      end
    end
  end

  // Configuration and walk state.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 16'd1;
      image_height <= 16'd1;
      current_pass <= '0;
      pass_column  <= '0;
      pass_row     <= '0;
      restart      <= 1'b1;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          image_width <= DIM_WIDTH'(cfg_data[DIM_BITS-1:0]);
          pass_column <= '0;
          pass_row    <= '0;
          restart     <= 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          image_height <= DIM_WIDTH'(cfg_data[DIM_BITS-1:0]);
          pass_column  <= '0;
          pass_row     <= '0;
          restart      <= 1'b1;
        end
        REG_BITS_PER_PIXEL: begin
          // The pixel size affects no output, but the write still restarts the walk.
          pass_column <= '0;
          pass_row    <= '0;
          restart     <= 1'b1;
        end
        default: begin
        end
      endcase
    end else if (in_fire && geom.any) begin
      current_pass <= eff_pass;
      restart      <= 1'b0;
      if (!at_last_col) begin
        pass_column <= pass_column + COORD_BITS'(1);
      end else begin
        pass_column <= '0;
        if (!at_last_row) begin
          pass_row <= pass_row + COORD_BITS'(1);
        end else begin
          pass_row <= '0;
          if (next_found) begin
            current_pass <= next_pass;
          end else begin
            restart <= 1'b1;
          end
        end
      end
    end
  end

  // Stage one register. A pixel arriving with no nonempty pass is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= geom.any;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_value <= s_axis_tdata;
      s1_col   <= col_now;
      s1_row   <= row_now;
      s1_last  <= at_last_col && at_last_row && !next_found;
    end
  end

  // Output register; the linear index multiply lands here.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      m_axis_tdata[63:0]   <= s1_value;
      m_axis_tdata[79:64]  <= s1_col;
      m_axis_tdata[95:80]  <= s1_row;
      m_axis_tdata[127:96] <= 32'(s1_row) * 32'(image_width) + 32'(s1_col);
      m_axis_tlast         <= s1_last;
    end
  end

`ifndef SYNTHESIS
  // A pending restart always comes with the position at the origin.
  assert property (@(posedge clk) disable iff (rst)
    restart |-> (pass_column == '0) && (pass_row == '0))
    else $error("restart pending with nonzero pass position");

  // Outside a restart the walk points inside a nonempty pass.
  assert property (@(posedge clk) disable iff (rst)
    !restart |-> geom.nonempty[current_pass] &&
      (CMP_BITS'(pass_column) <= CMP_BITS'(geom.last_col[current_pass])) &&
      (CMP_BITS'(pass_row) <= CMP_BITS'(geom.last_row[current_pass])))
    else $error("pass position outside its pass");

  // A stage-one pixel is never lost while the output is stalled.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && m_axis_tvalid && !m_axis_tready |=> s1_valid)
    else $error("stage one pixel dropped under backpressure");
`endif

endmodule

`default_nettype wire

/* test/tb_adam7_deinterlace_addr_core.sv */
// Self-checking testbench for adam7_deinterlace_addr_core.
// Streams interlaced pixels through the core and checks every result beat against a
// built-in model of the Adam7 pass walk; depends on a7da_pkg and the core itself.
`timescale 1ns / 1ps

module tb_adam7_deinterlace_addr_core;
  import a7da_pkg::*;

  // Index 3 is not a register; a write there must be ignored and must not restart.
  localparam logic [1:0] REG_SPARE = 2'd3;

  // Cycles to let pass after the last expected beat before touching the registers,
  // so that pixels dropped in an empty image have left the two-stage pipeline.
  localparam int SETTLE = 6;
  // Cycles without any handshake at all before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  // Random beats with a result to aim for after the directed part.
  localparam int RANDOM_TARGET = 870;

  typedef struct packed {
    logic [63:0] value;
    logic [15:0] column;
    logic [15:0] row;
    logic [31:0] index;
    logic        last;
  } placed_pixel_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tlast;

  always #4 clk = ~clk;

  adam7_deinterlace_addr_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Expected output beats, oldest first.
  placed_pixel_t placed_q[$];
  int failures = 0;
  int results_due = 0;
  int idle_pct = 8;
  int quiet_cycles = 0;

  // Shadow copy of the size registers and of the position inside the pass walk.
  int unsigned img_w, img_h, img_bpp;
  int unsigned walk_pass, walk_col, walk_row;

  // ---------------------------------------------------------------------------
  // Pass walk model
  // ---------------------------------------------------------------------------

  // Origin and stride of each Adam7 pass in the full image (passes held as 0..6).
  function automatic int unsigned org_x(int unsigned p);
    case (p)
      1: return 4;
      3: return 2;
      5: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned org_y(int unsigned p);
    case (p)
      2: return 4;
      4: return 2;
      6: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned stride_x(int unsigned p);
    case (p)
      0, 1: return 8;
      2, 3: return 4;
      4, 5: return 2;
      default: return 1;
    endcase
  endfunction

  function automatic int unsigned stride_y(int unsigned p);
    case (p)
      0, 1, 2: return 8;
      3, 4: return 4;
      default: return 2;
    endcase
  endfunction

  // Number of pass positions that fall inside a dimension of the given size.
  function automatic int unsigned span(int unsigned full, int unsigned first,
                                       int unsigned step);
    if (full <= first) return 0;
    return (full - first + step - 1) / step;
  endfunction

  function automatic int unsigned pass_cols(int unsigned p);
    return span(img_w, org_x(p), stride_x(p));
  endfunction

  function automatic int unsigned pass_rows(int unsigned p);
    return span(img_h, org_y(p), stride_y(p));
  endfunction

  function automatic bit has_pixels(int unsigned p);
    return pass_cols(p) != 0 && pass_rows(p) != 0;
  endfunction

  // First pass at or after p that holds any pixel, NUM_PASSES when none does.
  function automatic int unsigned next_filled(int unsigned p);
    while (p < NUM_PASSES && !has_pixels(p)) p++;
    return p;
  endfunction

  function automatic void rewind_walk();
    int unsigned p;
    p = next_filled(0);
    walk_pass = (p < NUM_PASSES) ? p : 0;
    walk_col = 0;
    walk_row = 0;
  endfunction

  function automatic void reset_shadow();
    img_w = 1;
    img_h = 1;
    img_bpp = 8;
    rewind_walk();
  endfunction

  // Any write to a real register restarts the walk for the new size.
  function automatic void apply_register(logic [1:0] idx, logic [15:0] val);
    case (idx)
      REG_IMAGE_WIDTH:    img_w = val;
      REG_IMAGE_HEIGHT:   img_h = val;
      REG_BITS_PER_PIXEL: img_bpp = val & 16'h007F;
      default: return;
    endcase
    rewind_walk();
  endfunction

  // Places one accepted pixel in the image and queues the beat it should produce.
  function automatic void place_pixel(logic [63:0] v);
    placed_pixel_t r;
    int unsigned p, ncol, nrow, x, y, nxt;
    longint unsigned lin;
    bit last;
    // An image with a zero dimension has no pixel at all: the beat is dropped.
    if (next_filled(0) >= NUM_PASSES) return;
    if (walk_pass >= NUM_PASSES || !has_pixels(walk_pass) ||
        walk_col >= pass_cols(walk_pass) || walk_row >= pass_rows(walk_pass))
      rewind_walk();
    p = walk_pass;
    ncol = pass_cols(p);
    nrow = pass_rows(p);
    x = org_x(p) + walk_col * stride_x(p);
    y = org_y(p) + walk_row * stride_y(p);
    lin = longint'(y) * img_w + x;
    last = 1'b0;
    walk_col = (walk_col + 1) & 32'hFFFF;
    if (walk_col >= ncol) begin
      walk_col = 0;
      walk_row = (walk_row + 1) & 32'hFFFF;
      if (walk_row >= nrow) begin
        walk_row = 0;
        nxt = next_filled(p + 1);
        if (nxt >= NUM_PASSES) begin
          // End of image: the walk goes back to the start of the first nonempty pass.
          last = 1'b1;
          rewind_walk();
        end else begin
          walk_pass = nxt;
        end
      end
    end
    r.value = v;
    r.column = x[15:0];
    r.row = y[15:0];
    r.index = lin[31:0];
    r.last = last;
    placed_q.push_back(r);
    results_due++;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic bit take_break();
    return (idle_pct != 0) && ($urandom_range(99) < idle_pct);
  endfunction

  function automatic logic [63:0] pick_pixel();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offers one pixel beat and returns at the edge that accepts it. Valid stays high
  // so that the next call can follow without a gap; end_burst lowers it.
  task automatic send_pixel(input logic [63:0] v);
    while (take_break()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    do @(posedge clk); while (!s_axis_tready);
    place_pixel(v);
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_burst(input int unsigned n);
    repeat (n) send_pixel(pick_pixel());
    end_burst();
  endtask

  // Waits for every expected beat, then for the pipeline to empty of dropped pixels.
  task automatic wait_drained();
    while (placed_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and back-pressure
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    placed_pixel_t want;
    m_axis_tready <= !take_break();
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (placed_q.size() == 0) begin
        $error("result beat with no pixel waiting for it");
        failures++;
      end else begin
        want = placed_q.pop_front();
        if (m_axis_tdata[63:0] !== want.value) begin
          $error("out_value: expected %h, got %h", want.value, m_axis_tdata[63:0]);
          failures++;
        end
        if (m_axis_tdata[79:64] !== want.column) begin
          $error("dest_column: expected %0d, got %0d", want.column, m_axis_tdata[79:64]);
          failures++;
        end
        if (m_axis_tdata[95:80] !== want.row) begin
          $error("dest_row: expected %0d, got %0d", want.row, m_axis_tdata[95:80]);
          failures++;
        end
        if (m_axis_tdata[127:96] !== want.index) begin
          $error("dest_index: expected %0d, got %0d", want.index, m_axis_tdata[127:96]);
          failures++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_pixel: expected %0d, got %0d", want.last, m_axis_tlast);
          failures++;
        end
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The reset size is one by one, so every pixel is the whole image.
  task automatic test_reset_size();
    send_pixel(64'd0);
    send_pixel('1);
    end_burst();
  endtask

  // A three by three image touches five of the seven passes. Eleven pixels run
  // past the end of the image into the next one; halfway through, the sender
  // holds off until every result has come out.
  task automatic test_frame_wrap();
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    send_burst(5);
    while (placed_q.size() != 0) @(posedge clk);
    send_burst(6);
  endtask

  // The walk is now in the middle of an image. Writing the pixel size restarts it;
  // a write to the unused index must leave the position alone.
  task automatic test_register_restart();
    write_reg(REG_BITS_PER_PIXEL, 16'd1);
    send_burst(2);
    write_reg(REG_SPARE, 16'hFFFF);
    send_burst(1);
    write_reg(REG_BITS_PER_PIXEL, 16'd64);
    send_burst(1);
  endtask

  // With a zero width or height the pixels are accepted and dropped.
  task automatic test_empty_image();
    write_reg(REG_IMAGE_WIDTH, 16'd0);
    send_burst(2);
    write_reg(REG_IMAGE_WIDTH, 16'd5);
    write_reg(REG_IMAGE_HEIGHT, 16'd0);
    send_burst(2);
  endtask

  // The largest image the registers can describe.
  task automatic test_widest_image();
    write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
    send_burst(4);
  endtask

  function automatic logic [15:0] pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return 16'd0;
    if (r < 12) return 16'($urandom_range(65535));
    if (r < 16) return 16'hFFFF;
    if (r < 36) return 16'($urandom_range(13, 40));
    return 16'($urandom_range(1, 12));
  endfunction

  function automatic logic [15:0] pick_bpp();
    case ($urandom_range(11))
      0: return 16'd1;
      1: return 16'd2;
      2: return 16'd4;
      3: return 16'd8;
      4: return 16'd16;
      5: return 16'd24;
      6: return 16'd32;
      7: return 16'd48;
      8: return 16'd64;
      9: return 16'($urandom_range(127));
      default: return 16'($urandom);
    endcase
  endfunction

  // Random image sizes. Most small images are streamed whole, once or twice and a
  // little beyond, so that every pass and the image end are crossed many times;
  // large ones get a short partial run. The last burst is cut to the target.
  task automatic test_random_images();
    int phase;
    int stop_at;
    int unsigned area, n;
    phase = 0;
    stop_at = results_due + RANDOM_TARGET;
    while (results_due < stop_at) begin
      // A few phases run with no idling on either side.
      idle_pct = (phase >= 5 && phase < 9) ? 0 : 8;
      if (phase == 0 || $urandom_range(2) != 0) write_reg(REG_IMAGE_WIDTH, pick_dim());
      if (phase == 0 || $urandom_range(2) != 0) write_reg(REG_IMAGE_HEIGHT, pick_dim());
      if (phase == 0 || $urandom_range(3) == 0) write_reg(REG_BITS_PER_PIXEL, pick_bpp());
      if ($urandom_range(15) == 0) write_reg(REG_SPARE, 16'($urandom));
      area = img_w * img_h;
      if (area == 0)
        n = $urandom_range(1, 5);
      else if (area <= 300 && $urandom_range(3) != 0)
        n = area * $urandom_range(1, 2) + $urandom_range(0, 3);
      else if (area <= 300)
        n = $urandom_range(1, area);
      else
        n = $urandom_range(1, 60);
      if (n > $unsigned(stop_at - results_due)) n = $unsigned(stop_at - results_due);
      send_burst(n);
      phase++;
    end
    idle_pct = 8;
  endtask

  initial begin
    reset_shadow();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_size();
    test_frame_wrap();
    test_register_restart();
    test_empty_image();
    test_widest_image();
    test_random_images();
    wait_drained();
    if (placed_q.size() != 0) begin
      $error("%0d expected result beats never arrived", placed_q.size());
      failures++;
    end
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
